/* rtl/bfs_pkg.sv */
package bfs_pkg;

  localparam int HASH_W        = 32;
  localparam int CHAR_W        = 8;
  localparam int FILTER_BITS_W = 17;
  localparam int HASH_EN_W     = 3;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 17;
  localparam int DIV_CNT_W     = 5;

  localparam logic [HASH_W-1:0] BKDR_MUL = 32'd131;
  localparam logic [HASH_W-1:0] SDBM_MUL = 32'd65599;
  localparam logic [HASH_W-1:0] RS_START = 32'd63689;
  localparam logic [HASH_W-1:0] RS_STEP  = 32'd378551;

  localparam logic [CFG_INDEX_W-1:0] IDX_FILTER_BITS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] IDX_HASH_ENABLE = 8'd1;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // hash unit control from the sequencer
  typedef struct packed {
    logic mul;      // form products of current accumulators
    logic add;      // fold in the character
    logic restart;  // back to start values after a string
  } hash_ctl_t;

endpackage

/* rtl/bloom_filter_string_membership_core.sv */
// Bloom filter over byte strings.
// Input stream (s_*): one character per word, s_tdata[7:0] signed char,
// s_tlast marks the final character, s_tuser is the mode (0 insert,
// 1 query) and only counts on the final character.
// Output stream (m_*): one word per query string, m_tdata[0] = 1 when all
// selected filter bits are set (maybe present), 0 when definitely absent.
// Inserts produce no output word.
// Config channel (cfg_*): index 0 filter_bits (0 or above the store size
// means full size), index 1 hash_enable (bit0 BKDR, bit1 SDBM, bit2 RS).
// Other indexes are dropped; cfg_ready is always high.
// Timing: a character is taken, then added. The last character adds, per
// enabled hash, a select step, one pass through the 1-bit-per-cycle
// divider (hash mod size), then a read and a write/test of the bit
// memory; a disabled hash takes only its select step. A final select
// step leads to the done state, which posts a query's result.
// Reset: the bit memory is zeroed by a sweep of one word per cycle;
// s_tready stays low during the sweep, config writes are still taken.
// Stall: the result sits in an output register; new characters are taken
// while it waits, and a later query result waits for it to drain.
module bloom_filter_string_membership_core
  import bfs_pkg::*;
#(
  parameter int MAX_FILTER_BITS = 65536,
  parameter int WORD_BITS       = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // s_tdata: [7:0] char_value
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,
  input  logic                   s_tlast,
  // s_tuser: [0] mode
  input  logic                   s_tuser,
  // m_tdata: [0] maybe_present, [7:1] zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // store word is WORD_BITS rounded up to a power of two, so word and bit
  // come straight from the position bits
  localparam int BW          = $clog2(WORD_BITS);
  localparam int LANE_BITS   = 1 << BW;
  localparam int STORE_WORDS = (MAX_FILTER_BITS + LANE_BITS - 1) / LANE_BITS;
  localparam int AW   = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int DIVW = $clog2(MAX_FILTER_BITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_MOD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]               state;
  logic [FILTER_BITS_W-1:0] filter_bits;
  logic [HASH_EN_W-1:0]     hash_enable;
  logic                     mode;
  logic                     last;
  logic signed [CHAR_W-1:0] char_reg;
  logic [1:0]               k;
  logic                     all_set;
  logic [AW-1:0]            addr;
  logic [BW-1:0]            bitsel;
  logic                     out_valid;
  logic                     out_bit;

  hash_ctl_t         hash_ctl;
  logic [HASH_W-1:0] bkdr;
  logic [HASH_W-1:0] sdbm;
  logic [HASH_W-1:0] rs;
  logic [HASH_W-1:0] hv;

  logic              div_start;
  logic [HASH_W-1:0] div_dividend;
  logic [DIVW-1:0]   div_divisor;
  logic              div_done;
  logic [DIVW-1:0]   div_rem;

  logic [DIVW-1:0]      eff_size;
  logic                 rd_en;
  logic                 wr_en;
  logic [LANE_BITS-1:0] rdata;
  logic [LANE_BITS-1:0] mask;
  logic                 clr_busy;
  logic                 accept;
  logic                 out_load;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_bits <= FILTER_BITS_W'(65536);
      hash_enable <= 3'b111;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == IDX_FILTER_BITS) begin
        filter_bits <= cfg_data[FILTER_BITS_W-1:0];
      end else if (cfg_index == IDX_HASH_ENABLE) begin
        hash_enable <= cfg_data[HASH_EN_W-1:0];
      end
    end
  end

  // zero or oversized means full store
  always_comb begin
    if (filter_bits == '0 || 32'(filter_bits) > 32'(MAX_FILTER_BITS)) begin
      eff_size = DIVW'(MAX_FILTER_BITS);
    end else begin
      eff_size = DIVW'(filter_bits);
    end
  end

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE) && !clr_busy;

  always_comb begin
    unique case (k)
      2'd0:    hv = bkdr;
      2'd1:    hv = sdbm;
      default: hv = rs;
    endcase
  end

  assign hash_ctl.mul     = accept;
  assign hash_ctl.add     = (state == S_ADD);
  assign hash_ctl.restart = (state == S_DONE) && (mode == MODE_INSERT || out_load);

  // hash mod size; the remainder is the bit position
  assign div_start    = (state == S_SEL) && k != 2'd3 && hash_enable[k];
  assign div_dividend = hv;
  assign div_divisor  = eff_size;

  assign rd_en = (state == S_RD);
  assign wr_en = (state == S_MOD) && (mode == MODE_INSERT);
  assign mask  = LANE_BITS'(1) << bitsel;

  assign out_load = (state == S_DONE) && (mode == MODE_QUERY) &&
                    (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (accept) begin
      char_reg <= s_tdata;
      mode     <= s_tuser;
      last     <= s_tlast;
    end
    if (state == S_ADD) begin
      k       <= '0;
      all_set <= 1'b1;
    end else if (state == S_SEL && k != 2'd3 && !hash_enable[k]) begin
      k <= k + 1'b1;
    end else if (state == S_MOD) begin
      k <= k + 1'b1;
      if (mode == MODE_QUERY && !rdata[bitsel]) begin
        all_set <= 1'b0;
      end
    end
    if (state == S_DIV && div_done) begin
      addr   <= AW'(div_rem >> BW);
      bitsel <= div_rem[BW-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_ADD;
        S_ADD:  state <= last ? S_SEL : S_IDLE;
        S_SEL: begin
          priority if (k == 2'd3) begin
            state <= S_DONE;
          end else if (hash_enable[k]) begin
            state <= S_DIV;
          end else begin
            state <= S_SEL;
          end
        end
        S_DIV:  if (div_done) state <= S_RD;
        S_RD:   state <= S_MOD;
        S_MOD:  state <= S_SEL;
        S_DONE: if (mode == MODE_INSERT || out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_bit <= all_set;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_bit};

  bfs_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .ctl        (hash_ctl),
    .char_value (char_reg),
    .bkdr       (bkdr),
    .sdbm       (sdbm),
    .rs         (rs)
  );

  bfs_div #(
    .DIVW (DIVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  bfs_store #(
    .WORD_BITS (LANE_BITS),
    .DEPTH     (STORE_WORDS),
    .AW        (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .wr_en    (wr_en),
    .addr     (addr),
    .wdata    (rdata | mask),
    .rdata    (rdata),
    .clr_busy (clr_busy)
  );

endmodule

/* rtl/bfs_hash.sv */
module bfs_hash
  import bfs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  hash_ctl_t                ctl,
  input  logic signed [CHAR_W-1:0] char_value,
  output logic [HASH_W-1:0]        bkdr,
  output logic [HASH_W-1:0]        sdbm,
  output logic [HASH_W-1:0]        rs
);

  logic [HASH_W-1:0] rs_mult;
  logic [HASH_W-1:0] prod_bkdr;
  logic [HASH_W-1:0] prod_sdbm;
  logic [HASH_W-1:0] prod_rs;
  logic [HASH_W-1:0] prod_mult;
  logic [HASH_W-1:0] char_ext;

  assign char_ext = HASH_W'(char_value);

  // products registered before the add
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_bkdr <= bkdr * BKDR_MUL;
      prod_sdbm <= sdbm * SDBM_MUL;
      prod_rs   <= rs * rs_mult;
      prod_mult <= rs_mult * RS_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      bkdr    <= '0;
      sdbm    <= '0;
      rs      <= '0;
      rs_mult <= RS_START;
    end else if (ctl.add) begin
      bkdr    <= prod_bkdr + char_ext;
      sdbm    <= prod_sdbm + char_ext;
      rs      <= prod_rs + char_ext;
      rs_mult <= prod_mult;
    end
  end

endmodule

/* rtl/bfs_div.sv */
module bfs_div
  import bfs_pkg::*;
#(
  parameter int DIVW = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [DIVW-1:0]   divisor,
  output logic              done,
  output logic [DIVW-1:0]   rem
);

  // restoring divider, one quotient bit per cycle; only the remainder is kept
  logic [HASH_W-1:0]    num;
  logic [DIVW-1:0]      dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIVW:0]        trial;
  logic [DIVW:0]        diff;
  logic                 ge;

  assign trial = {rem, num[HASH_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[HASH_W-2:0], 1'b0};
      rem <= ge ? diff[DIVW-1:0] : trial[DIVW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/bfs_store.sv */
module bfs_store #(
  parameter int WORD_BITS = 32,
  parameter int DEPTH     = 2048,
  parameter int AW        = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic                 wr_en,
  input  logic [AW-1:0]        addr,
  input  logic [WORD_BITS-1:0] wdata,
  output logic [WORD_BITS-1:0] rdata,
  output logic                 clr_busy
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]        clr_addr;

  // zero sweep after reset, one word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/bfs_checker.sv */
module bfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word dropped or changed under stall");

  // memory sweep blocks input right after reset
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input accepted during memory sweep");

  // input is blocked while a taken character is added
  a_char_two_cycles: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("back to back characters accepted");

  // a non-final character never yields a result
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
    else $error("result without end of string");

endmodule

bind bloom_filter_string_membership_core bfs_checker u_bfs_checker (.*);

/* tb/sv/bloom_filter_string_membership_core_tb.sv */
`timescale 1ns / 1ps

module bloom_filter_string_membership_core_tb;
  import bfs_pkg::*;

  localparam int FULL_SIZE    = 65536;
  localparam int SETTLE_CYCLES = 320;   // settle time after the longest string end, three hashes
  localparam int HOLD_CYCLES   = 3000;  // one long sink stall

  // register indexes the block has no use for; writes must be dropped
  localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_LO = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_HI = 8'hFF;

  typedef struct {
    logic       mode;
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  // one string, up to eight characters, byte 0 sent first
  typedef struct packed {
    logic [3:0]      len;
    logic [7:0][7:0] text;
  } text_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [7:0]             m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bloom_filter_string_membership_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow of the filter
  logic [FILTER_BITS_W-1:0] size_reg = 17'd65536;
  logic [HASH_EN_W-1:0]     hash_en_reg = 3'd7;
  logic [HASH_W-1:0]        bkdr_h = '0;
  logic [HASH_W-1:0]        sdbm_h = '0;
  logic [HASH_W-1:0]        rs_h = '0;
  logic [HASH_W-1:0]        rs_mul = RS_START;
  bit                       filter_mem [0:FULL_SIZE-1];

  char_item_t pending_chars[$];
  logic       expected_presence[$];
  text_t      known_strs[$];

  int         mismatch_count = 0;
  logic       in_taken = 1'b0;
  logic       steady = 1'b0;     // no idling on either side
  logic       hold_req = 1'b0;   // ask the sink for its long stall
  logic       hold_done = 1'b0;
  int         hold_left = 0;
  char_item_t next_char;
  logic       want_hit;

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // fold one character into the running hashes; at string end set or test bits
  task automatic hash_and_probe(input logic mode, input logic [7:0] ch, input logic last);
    logic [HASH_W-1:0]      cx;
    logic [2:0][HASH_W-1:0] hv;
    logic [HASH_W-1:0]      span;
    logic [HASH_W-1:0]      pos;
    logic                   hit;
    cx = {{(HASH_W-CHAR_W){ch[7]}}, ch};
    bkdr_h = bkdr_h * BKDR_MUL + cx;
    sdbm_h = sdbm_h * SDBM_MUL + cx;
    rs_h   = rs_h * rs_mul + cx;
    rs_mul = rs_mul * RS_STEP;
    if (last) begin
      hv[0] = bkdr_h;
      hv[1] = sdbm_h;
      hv[2] = rs_h;
      // zero or oversized means full size
      span = (size_reg == 0 || size_reg > FULL_SIZE) ? FULL_SIZE : 32'(size_reg);
      hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (hash_en_reg[k]) begin
          pos = hv[k] % span;
          if (mode == MODE_INSERT) filter_mem[pos[15:0]] = 1'b1;
          else if (!filter_mem[pos[15:0]]) hit = 1'b0;
        end
      end
      bkdr_h = '0;
      sdbm_h = '0;
      rs_h   = '0;
      rs_mul = RS_START;
      if (mode == MODE_QUERY) expected_presence.push_back(hit);
    end
  endtask

  function automatic text_t make_text(input int n, input logic [7:0] c0,
                                      input logic [7:0] c1, input logic [7:0] c2);
    text_t t;
    t = '0;
    t.len = 4'(n);
    t.text[0] = c0;
    t.text[1] = c1;
    t.text[2] = c2;
    return t;
  endfunction

  function automatic text_t random_text();
    text_t t;
    t = '0;
    t.len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(5, 8)) : 4'($urandom_range(1, 4));
    for (int i = 0; i < 8; i++) begin
      if (i < t.len) t.text[i] = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom);
    end
    return t;
  endfunction

  // mode only matters on the final character; the others carry noise
  task automatic queue_string(input text_t t, input logic mode);
    char_item_t it;
    for (int i = 0; i < t.len; i++) begin
      it.ch   = t.text[i];
      it.last = (i == t.len - 1);
      it.mode = it.last ? mode : 1'($urandom_range(0, 1));
      pending_chars.push_back(it);
    end
  endtask

  // inserts, queries of stored strings (hits) and of fresh strings (mostly misses)
  task automatic fill_random(input int n);
    int    added;
    int    pick;
    text_t t;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 || known_strs.size() == 0) begin
        t = random_text();
        known_strs.push_back(t);
        queue_string(t, MODE_INSERT);
      end else if (pick < 70) begin
        t = known_strs[$urandom_range(0, known_strs.size() - 1)];
        queue_string(t, MODE_QUERY);
      end else begin
        t = random_text();
        queue_string(t, MODE_QUERY);
      end
      added += t.len;
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == IDX_FILTER_BITS) size_reg = val[FILTER_BITS_W-1:0];
    else if (idx == IDX_HASH_ENABLE) hash_en_reg = val[HASH_EN_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // all words sent, all answers back, and time for a trailing insert to finish
  task automatic drain();
    while (pending_chars.size() != 0 || s_tvalid || expected_presence.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // source side: new word at the falling edge once the last one was taken
  always @(posedge clk) in_taken <= s_tvalid && s_tready;

  always @(negedge clk) begin
    if (!s_tvalid || in_taken) begin
      if (pending_chars.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
        next_char = pending_chars.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_char.ch;
        s_tlast  <= next_char.last;
        s_tuser  <= next_char.mode;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink side, with one long stall so the output register and then the input back up
  always @(negedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 27);
    end
  end

  // monitor: predict on every accepted character, check every accepted answer
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) hash_and_probe(s_tuser, s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_presence.size() == 0) begin
          flag_mismatch($sformatf("unexpected answer m_tdata=%02h", m_tdata));
        end else begin
          want_hit = expected_presence.pop_front();
          if (m_tdata[0] !== want_hit)
            flag_mismatch($sformatf("maybe_present %b, want %b", m_tdata[0], want_hit));
          if (m_tdata[7:1] !== 7'd0)
            flag_mismatch($sformatf("padding bits set, m_tdata=%02h", m_tdata));
        end
      end
    end
  end

  initial begin
    logic [FILTER_BITS_W-1:0] fb_plan [9];
    logic [HASH_EN_W-1:0]     he_plan [9];
    text_t                    t;
    fb_plan = '{17'd1, 17'd0, 17'd131071, 17'd65537, 17'd37, 17'd65536, 17'd500,
                17'($urandom_range(1, 131071)), 17'd2};
    he_plan = '{3'd7, 3'd1, 3'd2, 3'd4, 3'd0, 3'd5, 3'd3, 3'($urandom_range(0, 7)), 3'd6};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pass at reset settings: full size, all three hashes
    queue_string(make_text(1, 8'h41, 8'h00, 8'h00), MODE_QUERY);  // empty filter
    t = make_text(3, 8'h7F, 8'h80, 8'h00);                        // char extremes, zero last
    queue_string(t, MODE_INSERT);
    queue_string(t, MODE_QUERY);
    queue_string(make_text(1, 8'h00, 8'h00, 8'h00), MODE_QUERY);
    t = make_text(2, 8'h00, 8'h00, 8'h00);
    queue_string(t, MODE_INSERT);
    queue_string(t, MODE_QUERY);
    t = make_text(1, 8'hFF, 8'h00, 8'h00);
    queue_string(t, MODE_INSERT);
    queue_string(t, MODE_QUERY);
    queue_string(make_text(1, 8'h01, 8'h00, 8'h00), MODE_QUERY);
    drain();

    for (int p = 0; p < 9; p++) begin
      write_reg(IDX_FILTER_BITS, fb_plan[p]);
      write_reg(IDX_HASH_ENABLE, CFG_DATA_W'(he_plan[p]));
      if (p == 6) begin
        // dropped writes: would clear all hashes / shrink the filter if taken
        write_reg(IDX_SPARE_LO, '0);
        write_reg(IDX_SPARE_HI, 17'd1);
      end
      hold_req = (p == 5);
      steady   = (p == 6);
      fill_random(88);
      drain();
      steady = 1'b0;
    end

    if (expected_presence.size() != 0)
      flag_mismatch($sformatf("%0d answers never came", expected_presence.size()));
    if (mismatch_count == 0) begin
      $display("[bloom_filter_string_membership_core] OK");
    end else begin
      $display("[bloom_filter_string_membership_core] ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("[bloom_filter_string_membership_core] ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/bfs_pkg.sv
rtl/bfs_hash.sv
rtl/bfs_div.sv
rtl/bfs_store.sv
rtl/bloom_filter_string_membership_core.sv
rtl/bfs_checker.sv
tb/sv/bloom_filter_string_membership_core_tb.sv
